FILE: hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // sizes and limits
    localparam int FFBA_MAX_BLOCKS = 64;
    localparam int HEAP_BYTES      = 1048576;
    localparam int HEADER_BYTES    = 24;

    // field widths
    localparam int PTR_W  = 21;
    localparam int OFF_W  = 20;
    localparam int TYPE_W = 2;
    localparam int ST_W   = 2;

    localparam logic [PTR_W-1:0] LIMIT_RESET = PTR_W'(1048576);

    // request types
    typedef logic [TYPE_W-1:0] t_req_type;
    localparam t_req_type REQ_ALLOC   = 2'd0;
    localparam t_req_type REQ_FREE    = 2'd1;
    localparam t_req_type REQ_REALLOC = 2'd2;

    // result status codes
    typedef logic [ST_W-1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OOM      = 2'd1;
    localparam t_status ST_BADFREE  = 2'd2;
    localparam t_status ST_NULLFREE = 2'd3;

    // table write selection
    typedef logic [1:0] t_wr_sel;
    localparam t_wr_sel WR_NONE    = 2'd0;
    localparam t_wr_sel WR_TAKE    = 2'd1;
    localparam t_wr_sel WR_APPEND  = 2'd2;
    localparam t_wr_sel WR_RELEASE = 2'd3;

    // result pointer source
    typedef logic [1:0] t_res_src;
    localparam t_res_src RES_ZERO  = 2'd0;
    localparam t_res_src RES_REQ   = 2'd1;
    localparam t_res_src RES_RD    = 2'd2;
    localparam t_res_src RES_BRK   = 2'd3;

    // channel payloads
    typedef struct packed {
        t_req_type        req_type;
        logic [PTR_W-1:0] req_size;
        logic [PTR_W-1:0] req_ptr;
    } t_req;

    typedef struct packed {
        logic [PTR_W-1:0] result_ptr;
        t_status          status;
    } t_rsp;

    // one block table entry
    typedef struct packed {
        logic [OFF_W-1:0] blk_offset;
        logic [PTR_W-1:0] blk_size;
        logic             blk_free;
    } t_blk;

    // controller to datapath
    typedef struct packed {
        logic     load_req;
        logic     scan_start;
        logic     scan_run;
        logic     cap_old;
        t_wr_sel  wr_sel;
        logic     res_load;
        t_res_src res_src;
        t_status  res_status;
        logic     out_load;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        t_req_type req_type;
        logic      ptr_zero;
        logic      find_hit;
        logic      fit_hit;
        logic      rd_free;
        logic      rd_fits;
        logic      scan_end;
        logic      app_ok;
        logic      out_free;
    } t_ctl_sts;

endpackage

FILE: hw/rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table, scan pipeline, heap break, result and output registers.
// ----------------------------------------------------------------------------
module ffba_datapath import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = FFBA_MAX_BLOCKS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [PTR_W-1:0] i_cfg_wdata,
    input  t_ctl_cmd         i_cmd,
    output t_ctl_sts         o_sts,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp
);

    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int END_W = PTR_W + 2;

    t_req             r_req;
    logic [PTR_W-1:0] r_heap_limit;
    logic [CW-1:0]    r_count;
    logic [PTR_W-1:0] r_break;
    logic [CW-1:0]    r_scan_addr;
    logic             r_scan_dv;
    logic [AW-1:0]    r_scan_idx;
    logic [AW-1:0]    r_old_idx;
    t_blk             r_old_blk;
    logic [PTR_W-1:0] r_res_ptr;
    t_status          r_res_status;
    logic             r_rsp_valid;
    t_rsp             r_rsp;

    t_blk             rd_blk;
    logic [$bits(t_blk)-1:0] rd_word;
    logic             rd_en;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_blk             wr_blk;
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] brk_ptr;
    logic [PTR_W-1:0] lim_eff;
    logic [END_W-1:0] app_end;
    logic             scan_more;
    logic [PTR_W-1:0] res_ptr_sel;

    // block table
    ffba_ram #(
        .WIDTH ($bits(t_blk)),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_blk),
        .i_re    (rd_en),
        .i_raddr (r_scan_addr[AW-1:0]),
        .o_rdata (rd_word)
    );

    assign rd_blk = t_blk'(rd_word);

    // payload offsets and append check
    assign rd_ptr    = {1'b0, rd_blk.blk_offset} + PTR_W'(HEADER_BYTES);
    assign brk_ptr   = r_break + PTR_W'(HEADER_BYTES);
    assign lim_eff   = (r_heap_limit > PTR_W'(HEAP_BYTES)) ? PTR_W'(HEAP_BYTES) : r_heap_limit;
    assign app_end   = {2'b00, r_break} + END_W'(HEADER_BYTES) + {2'b00, r_req.req_size};
    assign scan_more = (r_scan_addr < r_count);
    assign rd_en     = i_cmd.scan_run && scan_more;

    // status toward the controller
    always_comb begin
        o_sts.req_type = r_req.req_type;
        o_sts.ptr_zero = (r_req.req_ptr == '0);
        o_sts.rd_free  = rd_blk.blk_free;
        o_sts.rd_fits  = (rd_blk.blk_size >= r_req.req_size);
        o_sts.find_hit = r_scan_dv && (rd_ptr == r_req.req_ptr);
        o_sts.fit_hit  = r_scan_dv && rd_blk.blk_free && o_sts.rd_fits;
        o_sts.scan_end = !r_scan_dv && !scan_more;
        o_sts.app_ok   = (r_count < CW'(MAX_BLOCKS)) && (app_end <= {2'b00, lim_eff});
        o_sts.out_free = !r_rsp_valid || i_rsp_ready;
    end

    // table write selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_scan_idx;
        wr_blk  = rd_blk;
        unique case (i_cmd.wr_sel)
            WR_TAKE: begin
                wr_en           = 1'b1;
                wr_addr         = r_scan_idx;
                wr_blk          = rd_blk;
                wr_blk.blk_free = 1'b0;
            end
            WR_APPEND: begin
                wr_en             = 1'b1;
                wr_addr           = r_count[AW-1:0];
                wr_blk.blk_offset = r_break[OFF_W-1:0];
                wr_blk.blk_size   = r_req.req_size;
                wr_blk.blk_free   = 1'b0;
            end
            WR_RELEASE: begin
                wr_en           = 1'b1;
                wr_addr         = r_old_idx;
                wr_blk          = r_old_blk;
                wr_blk.blk_free = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // result pointer source
    always_comb begin
        unique case (i_cmd.res_src)
            RES_REQ: res_ptr_sel = r_req.req_ptr;
            RES_RD:  res_ptr_sel = rd_ptr;
            RES_BRK: res_ptr_sel = brk_ptr;
            default: res_ptr_sel = '0;
        endcase
    end

    // control registers: limit, count, break, scan pointer, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_limit <= LIMIT_RESET;
            r_count      <= '0;
            r_break      <= '0;
            r_scan_addr  <= '0;
            r_scan_dv    <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap_limit <= i_cfg_wdata;
            end
            if (i_cmd.wr_sel == WR_APPEND) begin
                r_count <= r_count + CW'(1);
                r_break <= app_end[PTR_W-1:0];
            end
            if (i_cmd.scan_start) begin
                r_scan_addr <= '0;
                r_scan_dv   <= 1'b0;
            end else if (rd_en) begin
                r_scan_addr <= r_scan_addr + CW'(1);
                r_scan_dv   <= 1'b1;
            end else begin
                r_scan_dv   <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (rd_en) begin
            r_scan_idx <= r_scan_addr[AW-1:0];
        end
        if (i_cmd.cap_old) begin
            r_old_idx <= r_scan_idx;
            r_old_blk <= rd_blk;
        end
        if (i_cmd.res_load) begin
            r_res_ptr    <= res_ptr_sel;
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.out_load) begin
            r_rsp.result_ptr <= r_res_ptr;
            r_rsp.status     <= r_res_status;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

FILE: hw/rtl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: decode, pointer lookup, first-fit scan, append, release.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_FIND    = 3'd2;
    localparam logic [2:0] S_FIT     = 3'd3;
    localparam logic [2:0] S_RELEASE = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_rel_pend;
    logic       n_rel_pend;

    assign o_req_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_rel_pend = r_rel_pend;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                n_rel_pend = 1'b0;
                unique case (i_sts.req_type)
                    REQ_ALLOC: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_FIT;
                    end
                    REQ_FREE: begin
                        if (i_sts.ptr_zero) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_src    = RES_ZERO;
                            o_cmd.res_status = ST_NULLFREE;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_FIND;
                        end
                    end
                    REQ_REALLOC: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = i_sts.ptr_zero ? S_FIT : S_FIND;
                    end
                    default: begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_src    = RES_ZERO;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_DONE;
                    end
                endcase
            end
            // look up the block that owns the request pointer
            S_FIND: begin
                if (i_sts.find_hit) begin
                    o_cmd.cap_old = 1'b1;
                    if (i_sts.rd_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_src    = RES_ZERO;
                        o_cmd.res_status = ST_BADFREE;
                        n_state          = S_DONE;
                    end else if (i_sts.req_type == REQ_FREE) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_src    = RES_ZERO;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_RELEASE;
                    end else if (i_sts.rd_fits) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_src    = RES_REQ;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_rel_pend       = 1'b1;
                        n_state          = S_FIT;
                    end
                end else if (i_sts.scan_end) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = RES_ZERO;
                    o_cmd.res_status = ST_BADFREE;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            // first free block that is large enough, else append at the break
            S_FIT: begin
                if (i_sts.fit_hit) begin
                    o_cmd.wr_sel     = WR_TAKE;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_src    = RES_RD;
                    o_cmd.res_status = ST_OK;
                    n_state          = r_rel_pend ? S_RELEASE : S_DONE;
                end else if (i_sts.scan_end) begin
                    if (i_sts.app_ok) begin
                        o_cmd.wr_sel     = WR_APPEND;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_src    = RES_BRK;
                        o_cmd.res_status = ST_OK;
                        n_state          = r_rel_pend ? S_RELEASE : S_DONE;
                    end else begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_src    = RES_ZERO;
                        o_cmd.res_status = ST_OOM;
                        n_state          = S_DONE;
                    end
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            // mark the looked-up block free
            S_RELEASE: begin
                o_cmd.wr_sel = WR_RELEASE;
                n_state      = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rel_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rel_pend <= n_rel_pend;
        end
    end

endmodule

FILE: hw/rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator over a table of blocks in address order.
//
// channel   direction  handshake                     payload
// req       in         i_req_valid / o_req_ready     i_req (t_req)
// rsp       out        o_rsp_valid / i_rsp_ready     o_rsp (t_rsp)
// cfg       in         i_cfg_we                      i_cfg_wdata (heap limit)
//
// One request at a time. A free or reallocate looks its pointer up in the
// table, one entry per cycle; an allocate scans for the first fitting free
// block, also one entry per cycle (single table read port). Reset is
// synchronous and needs no clearing pass; the table is only read below the
// block count. The result sits in an output register, so a new request is
// taken while an earlier result waits for o_rsp transfer.
// ----------------------------------------------------------------------------
module first_fit_block_allocator import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = FFBA_MAX_BLOCKS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [PTR_W-1:0] i_cfg_wdata
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // sequencer
    ffba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // table and arithmetic
    ffba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule
